### sv/dssc_pkg.sv
// Package for the digit string split counter.
// Shared constants, controller state type and the command/status structs.
// No dependencies.
package dssc_pkg;

	localparam int MAX_DIGITS_DEF = 10;

	localparam int BOUND_W = 31;
	localparam int COUNT_W = 30;
	localparam int DIGIT_W = 4;
	localparam int PROD_W  = BOUND_W + DIGIT_W;

	localparam logic [COUNT_W-1:0] WAY_MODULUS       = 30'd1000000007;
	localparam logic [BOUND_W-1:0] UPPER_BOUND_RESET = 31'd1000000000;
	localparam logic [BOUND_W-1:0] BOUND_ALL_ONES    = 31'h7FFF_FFFF;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX         = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_COMMIT
	} dssc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // request accepted: shift digit in, start a walk
		logic step;    // one window entry
		logic commit;  // push count into history, post result on last
	} dssc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done;
		logic last;
		logic out_busy;
	} dssc_sts_t;

endpackage

### sv/dssc_ctrl.sv
// Controller for the digit string split counter.
// Sequences load, window walk and commit; depends on dssc_pkg.
module dssc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dssc_pkg::dssc_sts_t sts,
	output dssc_pkg::dssc_cmd_t cmd
);
	import dssc_pkg::*;

	dssc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// a final count waits until the output register is free
				if (!(sts.last && sts.out_busy)) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/dssc_dp.sv
// Datapath for the digit string split counter: digit window, count history,
// value/weight walk, modular sum and output register. Depends on dssc_pkg.
module dssc_dp #(
	parameter int MAX_DIGITS = dssc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dssc_pkg::dssc_cmd_t           cmd,
	output dssc_pkg::dssc_sts_t           sts,
	input  logic [dssc_pkg::DIGIT_W-1:0]  digit,
	input  logic                          last_digit,
	input  logic                          cfg_we,
	input  logic [dssc_pkg::BOUND_W-1:0]  cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dssc_pkg::COUNT_W-1:0]  way_count
);
	import dssc_pkg::*;

	localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int SEEN_W = $clog2(MAX_DIGITS + 1);

	logic [DIGIT_W-1:0] dig_q [MAX_DIGITS];
	logic [COUNT_W-1:0] pfx_q [MAX_DIGITS];
	logic [SEEN_W-1:0]  seen_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BOUND_W-1:0] val_q;
	logic [BOUND_W-1:0] wgt_q;
	logic               wbig_q;
	logic [COUNT_W-1:0] sum_q;
	logic               last_q;
	logic [BOUND_W-1:0] bound_q;
	logic [COUNT_W-1:0] way_q;
	logic               out_valid_q;

	logic [DIGIT_W-1:0] digit_sat;
	logic [DIGIT_W-1:0] lead;
	logic [PROD_W:0]    val_new;
	logic [PROD_W-1:0]  wgt_x10;
	logic               over;
	logic               at_end;
	logic [COUNT_W:0]   sum_raw;
	logic [COUNT_W-1:0] sum_add;

	assign digit_sat = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
	assign lead      = dig_q[idx_q];

	// exact weight is kept while it fits 31 bits; beyond that any nonzero
	// lead digit already exceeds the bound
	assign val_new = (PROD_W+1)'(val_q) + (PROD_W+1)'(PROD_W'(lead) * PROD_W'(wgt_q));
	assign wgt_x10 = PROD_W'({wgt_q, 3'b000}) + PROD_W'({wgt_q, 1'b0});
	assign over    = wbig_q ? (lead != '0) : (val_new > (PROD_W+1)'(bound_q));
	assign at_end  = (SEEN_W'(idx_q) == (seen_q - SEEN_W'(1)));

	assign sum_raw = (COUNT_W+1)'(sum_q) + (COUNT_W+1)'(pfx_q[idx_q]);
	assign sum_add = (sum_raw >= (COUNT_W+1)'(WAY_MODULUS)) ?
		COUNT_W'(sum_raw - (COUNT_W+1)'(WAY_MODULUS)) : COUNT_W'(sum_raw);

	assign sts.walk_done = over || at_end;
	assign sts.last      = last_q;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign way_count = way_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= UPPER_BOUND_RESET;
		end else if (cfg_we) begin
			bound_q <= cfg_wdata;
		end
	end

	// digit window, newest at index 0
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dig_q[0] <= digit_sat;
			for (int k = 1; k < MAX_DIGITS; k++) begin
				dig_q[k] <= dig_q[k-1];
			end
		end
	end

	// count history; only index 0 must hold f(0) at the start of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q[0] <= COUNT_W'(1);
			for (int k = 1; k < MAX_DIGITS; k++) begin
				pfx_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			pfx_q[0] <= last_q ? COUNT_W'(1) : sum_q;
			for (int k = 1; k < MAX_DIGITS; k++) begin
				pfx_q[k] <= pfx_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && (seen_q < SEEN_W'(MAX_DIGITS))) begin
				seen_q <= seen_q + SEEN_W'(1);
			end else if (cmd.commit && last_q) begin
				seen_q <= '0;
			end
			if (cmd.commit && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= last_digit;
			idx_q  <= '0;
			val_q  <= '0;
			wgt_q  <= BOUND_W'(1);
			wbig_q <= 1'b0;
			sum_q  <= '0;
		end else if (cmd.step && !over) begin
			idx_q <= idx_q + IDX_W'(1);
			if (!wbig_q) begin
				val_q <= val_new[BOUND_W-1:0];
			end
			if (lead != '0) begin
				sum_q <= sum_add;
			end
			if (wgt_x10 > PROD_W'(BOUND_ALL_ONES)) begin
				wbig_q <= 1'b1;
			end else begin
				wgt_q <= wgt_x10[BOUND_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && last_q) begin
			way_q <= sum_q;
		end
	end

endmodule

### sv/digit_string_split_counter.sv
// Channel  Signals                         Direction  Notes
// input    in_valid/in_ready, digit,        in         one digit per request
//          last_digit
// output   out_valid/out_ready, way_count   out        one count per string
// config   cfg_we, cfg_wdata                in         upper_bound, no wait
//
// A request passes through load, a walk of L window entries (1 .. MAX_DIGITS)
// on the shared value/sum unit, and commit.
// The walk stops early once the built value exceeds upper_bound.
// Reset clears the string state at once; upper_bound returns to 1000000000.
// A pending count does not block new digits; only a further final digit waits
// in commit while the output register still holds an untaken count.
// Top level of the digit string split counter; depends on dssc_pkg,
// dssc_ctrl and dssc_dp.
module digit_string_split_counter #(
	parameter int MAX_DIGITS = dssc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dssc_pkg::DIGIT_W-1:0]  digit,
	input  logic                          last_digit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dssc_pkg::COUNT_W-1:0]  way_count,
	input  logic                          cfg_we,
	input  logic [dssc_pkg::BOUND_W-1:0]  cfg_wdata
);
	import dssc_pkg::*;

	dssc_cmd_t cmd;
	dssc_sts_t sts;

	dssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dssc_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.digit      (digit),
		.last_digit (last_digit),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.way_count  (way_count)
	);

endmodule

### sv/dssc_chk.sv
// Port-level checks for the digit string split counter, bound to the top.
// Depends on dssc_pkg.
module dssc_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dssc_pkg::COUNT_W-1:0] way_count
);
	import dssc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(way_count))
		else $error("result changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (way_count < WAY_MODULUS))
		else $error("count not reduced");

	// a request always needs a walk before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken back to back");

	// a count is posted only from commit, never while idle
	a_post_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("count posted while idle");

endmodule

bind digit_string_split_counter dssc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.way_count (way_count)
);

### tb/tb_top.sv
// Self-checking testbench for digit_string_split_counter.
// Streams digit strings through the valid/ready channels against a split-count predictor;
// depends on dssc_pkg and the digit_string_split_counter RTL.
module tb_top;
	import dssc_pkg::*;

	localparam int WIN           = MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 3 * (WIN + 2);
	localparam int HOLD_CYCLES   = 400;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [DIGIT_W-1:0]  digit;
	logic                last_digit;
	logic                out_valid;
	logic                out_ready;
	logic [COUNT_W-1:0]  way_count;
	logic                cfg_we;
	logic [BOUND_W-1:0]  cfg_wdata;

	// predictor state: newest digit at index 0, hist_q[m] is the count m digits back
	logic [DIGIT_W-1:0]  win_q [WIN];
	logic [COUNT_W-1:0]  hist_q [WIN+1];
	int                  seen_q;
	logic [BOUND_W-1:0]  bound_q;
	logic [COUNT_W-1:0]  pending_counts [$];

	int  fail_count  = 0;
	int  cycle_count = 0;
	bit  hold_output = 1'b0;
	bit  steady_mode = 1'b0;
	bit  sender_busy = 1'b0;

	always #10 clk = ~clk;

	digit_string_split_counter #(.MAX_DIGITS(WIN)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.digit      (digit),
		.last_digit (last_digit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.way_count  (way_count),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	function automatic void clear_window();
		for (int k = 0; k < WIN; k++) begin
			win_q[k] = '0;
		end
		for (int k = 0; k <= WIN; k++) begin
			hist_q[k] = '0;
		end
		hist_q[0] = COUNT_W'(1);
		seen_q = 0;
	endfunction

	// Forward recurrence: sum the counts at every cut point giving an allowed number.
	function automatic bit count_splits_step(input logic [DIGIT_W-1:0] code, input logic fin,
			output logic [COUNT_W-1:0] cnt);
		logic [DIGIT_W-1:0] dg;
		longint unsigned    val;
		longint unsigned    wt;
		longint unsigned    acc;
		dg = (code > DIGIT_MAX) ? DIGIT_MAX : code;
		for (int k = WIN - 1; k > 0; k--) begin
			win_q[k] = win_q[k-1];
		end
		win_q[0] = dg;
		if (seen_q < WIN)
			seen_q++;
		val = 0;
		wt  = 1;
		acc = 0;
		for (int n = 0; n < seen_q; n++) begin
			val += longint'(win_q[n]) * wt;
			if (val > longint'(bound_q))
				break;
			if (win_q[n] != 0) begin
				acc += hist_q[n];
				if (acc >= longint'(WAY_MODULUS))
					acc -= longint'(WAY_MODULUS);
			end
			wt *= 10;
		end
		for (int k = WIN; k > 0; k--) begin
			hist_q[k] = hist_q[k-1];
		end
		hist_q[0] = acc[COUNT_W-1:0];
		cnt = acc[COUNT_W-1:0];
		if (fin)
			clear_window();
		return fin;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_mode || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DIGIT_W-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return DIGIT_W'($urandom_range(10, 15));
		if (r < 25)
			return '0;
		return DIGIT_W'($urandom_range(1, 9));
	endfunction

	// mostly ones and twos, so the count grows past the modulus
	function automatic logic [DIGIT_W-1:0] pick_dense_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return DIGIT_W'($urandom_range(1, 2));
		return pick_code();
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 12);
		return $urandom_range(13, 40);
	endfunction

	// input acceptance feeds the predictor; output acceptance is checked in the same edge
	always @(posedge clk) begin : monitor
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (count_splits_step(digit, last_digit, cnt))
					pending_counts.push_back(cnt);
			end
			if (out_valid && out_ready) begin
				if (pending_counts.size() == 0) begin
					$display("%0t: unexpected way_count: expected none, got %0d",
						$time, way_count);
					fail_count++;
				end else begin
					want = pending_counts.pop_front();
					if (way_count !== want) begin
						$display("%0t: way_count mismatch: expected %0d, got %0d",
							$time, want, way_count);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL digit_string_split_counter");
		$finish;
	end

	initial begin : receiver
		int stall_left;
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end else if (steady_mode) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 65) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// valid stays up across back-to-back requests; this task lowers it only when a gap is taken
	task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic fin);
		int gap;
		gap = sender_busy ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		digit      <= d;
		last_digit <= fin;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_string(input int len, input bit dense);
		for (int i = 0; i < len; i++) begin
			send_digit(dense ? pick_dense_code() : pick_code(), i == len - 1);
		end
	endtask

	task automatic send_number(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_digit(DIGIT_W'(s[i] - 8'd48), i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bound(input logic [BOUND_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		bound_q = v;
	endtask

	task automatic test_directed();
		// reset bound: single zero, single nine, saturated codes, number equal to the bound
		send_digit(4'd0, 1'b1);
		send_digit(4'd9, 1'b1);
		send_digit(4'd15, 1'b1);
		send_digit(4'd10, 1'b0);
		send_digit(4'd12, 1'b1);
		send_number("1000000000");
		wait_drained();
		// zero bound admits nothing
		set_bound('0);
		send_digit(4'd7, 1'b0);
		send_digit(4'd3, 1'b1);
		wait_drained();
		set_bound(BOUND_ALL_ONES);
		send_number("2147483647");
		wait_drained();
	endtask

	task automatic test_bound_sweep();
		logic [BOUND_W-1:0] bounds [10];
		int sent;
		int len;
		bounds = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd26, 31'd100, UPPER_BOUND_RESET,
			BOUND_ALL_ONES, 31'($urandom_range(2, 99999)), 31'($urandom)};
		foreach (bounds[b]) begin
			set_bound(bounds[b]);
			sent = 0;
			while (sent < 60) begin
				len = pick_len();
				send_string(len, $urandom_range(0, 3) == 0);
				sent += len;
			end
			wait_drained();
		end
	endtask

	task automatic test_random_strings();
		int sent;
		int len;
		set_bound(UPPER_BOUND_RESET);
		sent = 0;
		while (sent < 700) begin
			len = pick_len();
			send_string(len, 1'b0);
			sent += len;
		end
		wait_drained();
	endtask

	// long strings wrap the count past the modulus and run far beyond the window
	task automatic test_long_strings();
		logic [BOUND_W-1:0] bounds [4];
		bounds = '{31'd26, UPPER_BOUND_RESET, BOUND_ALL_ONES, 31'd99};
		foreach (bounds[b]) begin
			set_bound(bounds[b]);
			send_string($urandom_range(80, 130), 1'b1);
			wait_drained();
		end
	endtask

	// receiver holds off while the sender keeps offering short strings
	task automatic test_output_stall();
		set_bound(UPPER_BOUND_RESET);
		hold_output = 1'b1;
		sender_busy = 1'b1;
		for (int s = 0; s < 25; s++) begin
			send_string($urandom_range(1, 3), 1'b0);
		end
		sender_busy = 1'b0;
		wait_drained();
	endtask

	// sender waits for every count before the next string
	task automatic test_paced();
		for (int s = 0; s < 30; s++) begin
			send_string($urandom_range(1, 5), 1'b0);
			wait_drained();
		end
	endtask

	task automatic test_steady_stream();
		int sent;
		int len;
		steady_mode = 1'b1;
		sent = 0;
		while (sent < 100) begin
			len = pick_len();
			send_string(len, 1'b0);
			sent += len;
		end
		steady_mode = 1'b0;
		wait_drained();
	endtask

	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		digit      = '0;
		last_digit = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		bound_q    = UPPER_BOUND_RESET;
		clear_window();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_directed();
		test_bound_sweep();
		test_random_strings();
		test_long_strings();
		test_output_stall();
		test_paced();
		test_steady_stream();

		wait_drained();
		if (fail_count == 0)
			$display("PASS digit_string_split_counter");
		else
			$display("FAIL digit_string_split_counter");
		$finish;
	end

endmodule

### files.f
sv/dssc_pkg.sv
sv/dssc_ctrl.sv
sv/dssc_dp.sv
sv/digit_string_split_counter.sv
sv/dssc_chk.sv
tb/tb_top.sv
